### sv/vdi_pkg.sv
// ----------------------------------------------------------------------------
// Vertex dedup indexer package
// Shared widths, constants, register addresses and controller state codes.
// ----------------------------------------------------------------------------
package vdi_pkg;

   localparam int NUM_COMP        = 8;
   localparam int COMP_W          = 32;
   localparam int TOL_W           = 16;
   localparam int VIDX_W          = 20;
   localparam int CSR_DATA_W      = 32;
   localparam int CSR_ADDR_W      = 2;

   localparam int DEF_STORE_DEPTH = 1024;
   localparam int DEF_INDEX_BITS  = 20;

   localparam logic [TOL_W-1:0]      TOL_RESET    = 16'd7;
   localparam logic [CSR_ADDR_W-1:0] CSR_ADDR_TOL = 2'd0;

   typedef enum logic [1:0] {
      S_IDLE = 2'b01,
      S_SCAN = 2'b10
   } vdi_state_type;

endpackage

### sv/vdi_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module vdi_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 1024,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

### sv/vdi_cell.sv
// ----------------------------------------------------------------------------
// Dedup compare cell
// Holds one component of the query and of every stored vertex; checks the
// passing token's entry against the query and hands the token on.
// ----------------------------------------------------------------------------
module vdi_cell
   import vdi_pkg::*;
#(
   parameter int STORE_DEPTH = DEF_STORE_DEPTH,
   localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              flush,
   input  logic              load,
   input  logic [COMP_W-1:0] load_data,
   input  logic [TOL_W-1:0]  tolerance,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic              in_valid,
   input  logic [ADDR_W-1:0] in_idx,
   input  logic              in_ok,
   output logic              out_valid,
   output logic [ADDR_W-1:0] out_idx,
   output logic              out_ok
);

   logic [COMP_W-1:0] query_ff, query_in;
   logic [COMP_W-1:0] rd_data;
   logic              s1_valid_ff, s1_valid_in;
   logic [ADDR_W-1:0] s1_idx_ff;
   logic              s1_ok_ff;
   logic              out_valid_ff, out_valid_in;
   logic [ADDR_W-1:0] out_idx_ff;
   logic              out_ok_ff;
   logic [COMP_W:0]   diff;
   logic [COMP_W:0]   diff_plus_tol;
   logic              comp_match;

   vdi_ram #(
      .WIDTH (COMP_W),
      .DEPTH (STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (query_ff),
      .rd_en   (in_valid),
      .rd_addr (in_idx),
      .rd_data (rd_data)
   );

   // |q - s| < tol, difference at 33 bits so it never wraps
   always_comb begin
      diff          = {query_ff[COMP_W-1], query_ff} - {rd_data[COMP_W-1], rd_data};
      diff_plus_tol = diff + {{(COMP_W+1-TOL_W){1'b0}}, tolerance};
      if (diff[COMP_W]) begin
         comp_match = !diff_plus_tol[COMP_W] && (diff_plus_tol != '0);
      end else begin
         comp_match = (diff < {{(COMP_W+1-TOL_W){1'b0}}, tolerance});
      end
   end

   assign query_in     = load ? load_data : query_ff;
   assign s1_valid_in  = in_valid && !flush;
   assign out_valid_in = s1_valid_ff && !flush;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      query_ff   <= query_in;
      s1_idx_ff  <= in_idx;
      s1_ok_ff   <= in_ok;
      out_idx_ff <= s1_idx_ff;
      out_ok_ff  <= s1_ok_ff && comp_match;
   end

   assign out_valid = out_valid_ff;
   assign out_idx   = out_idx_ff;
   assign out_ok    = out_ok_ff;

endmodule

### sv/vertex_dedup_indexer_core.sv
// ----------------------------------------------------------------------------
// Vertex dedup indexer core
// Maps each incoming vertex to a global index, appending unseen vertices to
// a per-object store searched by a chain of eight compare cells.
// ----------------------------------------------------------------------------
// Search: the entries stored for the object pass through the 16-stage compare
//   chain in order; a hit strobes for the first matching entry, a miss once the
//   last entry leaves the chain, or without a search when none is stored.
// Throughput: one entry enters the chain per cycle and busy holds until the
//   strobe, so a new item is accepted only once the last result is strobed.
// Reset: clear count, base and chain valid bits, tolerance 7; no result stall.
// ----------------------------------------------------------------------------
module vertex_dedup_indexer_core
   import vdi_pkg::*;
#(
   parameter int STORE_DEPTH = DEF_STORE_DEPTH,
   parameter int INDEX_BITS  = DEF_INDEX_BITS
) (
   input  logic                     clock,
   input  logic                     reset,
   // configuration
   input  logic                     psel,
   input  logic                     penable,
   input  logic                     pwrite,
   input  logic [CSR_ADDR_W-1:0]    paddr,
   input  logic [CSR_DATA_W-1:0]    pwdata,
   output logic [CSR_DATA_W-1:0]    prdata,
   output logic                     pready,
   // vertex items in
   input  logic                     start,
   output logic                     busy,
   input  logic                     req_new_object,
   input  logic signed [COMP_W-1:0] req_pos_x,
   input  logic signed [COMP_W-1:0] req_pos_y,
   input  logic signed [COMP_W-1:0] req_pos_z,
   input  logic signed [COMP_W-1:0] req_norm_x,
   input  logic signed [COMP_W-1:0] req_norm_y,
   input  logic signed [COMP_W-1:0] req_norm_z,
   input  logic signed [COMP_W-1:0] req_tex_u,
   input  logic signed [COMP_W-1:0] req_tex_v,
   // index results out
   output logic                     rsp_valid,
   output logic [VIDX_W-1:0]        rsp_vertex_index,
   output logic                     rsp_is_new,
   output logic                     rsp_store_full
);

   localparam int ADDR_W = (STORE_DEPTH > 1) ? $clog2(STORE_DEPTH) : 1;
   localparam int CNT_W  = $clog2(STORE_DEPTH + 1);
   localparam int GW     = ((INDEX_BITS > CNT_W) ? INDEX_BITS : CNT_W) + 1;
   localparam logic [GW-1:0]    MAX_G     = (GW'(1) << INDEX_BITS) - GW'(1);
   localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(STORE_DEPTH);

   // ------------------------------------------------------------------
   // Configuration register
   // ------------------------------------------------------------------
   logic [TOL_W-1:0] tol_ff, tol_in;
   logic             csr_wr;

   assign csr_wr = psel && penable && pwrite && pready && (paddr == CSR_ADDR_TOL);
   assign tol_in = csr_wr ? pwdata[TOL_W-1:0] : tol_ff;
   assign pready = 1'b1;
   assign prdata = (paddr == CSR_ADDR_TOL) ? CSR_DATA_W'(tol_ff) : '0;

   // ------------------------------------------------------------------
   // Control state
   // ------------------------------------------------------------------
   vdi_state_type    state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [GW-1:0]    base_ff, base_in;
   logic [CNT_W-1:0] issue_ff, issue_in;

   logic rsp_valid_ff, rsp_valid_in;
   logic [VIDX_W-1:0] rsp_index_ff, rsp_index_in;
   logic rsp_new_ff, rsp_new_in;
   logic rsp_full_ff, rsp_full_in;

   logic accept;
   logic [GW-1:0] base_sum;

   // chain wiring: entry 0 is the injector, entry NUM_COMP the chain end
   logic              tok_valid [NUM_COMP+1];
   logic [ADDR_W-1:0] tok_idx   [NUM_COMP+1];
   logic              tok_ok    [NUM_COMP+1];
   logic [COMP_W-1:0] query     [NUM_COMP];

   logic chain_hit, chain_last, finish, is_miss, store_room, wr_en;
   logic [GW-1:0] gidx_raw;
   logic [GW+VIDX_W-1:0] gidx_ext;

   assign accept = start && !busy;
   assign busy   = (state_ff != S_IDLE);

   assign query[0] = req_pos_x;
   assign query[1] = req_pos_y;
   assign query[2] = req_pos_z;
   assign query[3] = req_norm_x;
   assign query[4] = req_norm_y;
   assign query[5] = req_norm_z;
   assign query[6] = req_tex_u;
   assign query[7] = req_tex_v;

   // Inject one entry per cycle, every token starts as a match
   assign tok_valid[0] = (state_ff == S_SCAN) && (issue_ff < count_ff);
   assign tok_idx[0]   = issue_ff[ADDR_W-1:0];
   assign tok_ok[0]    = 1'b1;

   genvar gc;
   generate
      for (gc = 0; gc < NUM_COMP; gc++) begin : g_cell
         vdi_cell #(
            .STORE_DEPTH (STORE_DEPTH)
         ) u_cell (
            .clock     (clock),
            .reset     (reset),
            .flush     (finish),
            .load      (accept),
            .load_data (query[gc]),
            .tolerance (tol_ff),
            .wr_en     (wr_en),
            .wr_addr   (count_ff[ADDR_W-1:0]),
            .in_valid  (tok_valid[gc]),
            .in_idx    (tok_idx[gc]),
            .in_ok     (tok_ok[gc]),
            .out_valid (tok_valid[gc+1]),
            .out_idx   (tok_idx[gc+1]),
            .out_ok    (tok_ok[gc+1])
         );
      end
   endgenerate

   // Tokens leave the chain in entry order, so the first hit is the earliest
   assign chain_hit  = tok_valid[NUM_COMP] && tok_ok[NUM_COMP];
   assign chain_last = tok_valid[NUM_COMP] && !tok_ok[NUM_COMP]
                       && (CNT_W'(tok_idx[NUM_COMP]) == count_ff - CNT_W'(1));
   assign is_miss    = (count_ff == '0) || chain_last;
   assign finish     = (state_ff == S_SCAN) && (chain_hit || is_miss);
   assign store_room = (count_ff < DEPTH_CNT);
   assign wr_en      = finish && !chain_hit && store_room;

   // Fold the finished object's count into the base, saturating
   assign base_sum = base_ff + GW'(count_ff);
   assign gidx_raw = chain_hit ? (base_ff + GW'(tok_idx[NUM_COMP]))
                               : (base_ff + GW'(count_ff));
   assign gidx_ext = {{VIDX_W{1'b0}}, gidx_raw};

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      base_in      = base_ff;
      issue_in     = issue_ff;
      rsp_valid_in = 1'b0;
      rsp_index_in = rsp_index_ff;
      rsp_new_in   = rsp_new_ff;
      rsp_full_in  = rsp_full_ff;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               issue_in = '0;
               state_in = S_SCAN;
               if (req_new_object) begin
                  base_in  = (base_sum > MAX_G) ? MAX_G : base_sum;
                  count_in = '0;
               end
            end
         end
         S_SCAN: begin
            if (tok_valid[0]) begin
               issue_in = issue_ff + CNT_W'(1);
            end
            if (finish) begin
               state_in     = S_IDLE;
               rsp_valid_in = 1'b1;
               if (!chain_hit && !store_room) begin
                  // no room: drop the vertex
                  rsp_index_in = '0;
                  rsp_new_in   = 1'b0;
                  rsp_full_in  = 1'b1;
               end else begin
                  rsp_new_in = !chain_hit;
                  if (gidx_raw > MAX_G) begin
                     rsp_index_in = VIDX_W'({{VIDX_W{1'b0}}, MAX_G});
                     rsp_full_in  = 1'b1;
                  end else begin
                     rsp_index_in = gidx_ext[VIDX_W-1:0];
                     rsp_full_in  = 1'b0;
                  end
                  if (!chain_hit) begin
                     count_in = count_ff + CNT_W'(1);
                  end
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         base_ff      <= '0;
         issue_ff     <= '0;
         tol_ff       <= TOL_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         base_ff      <= base_in;
         issue_ff     <= issue_in;
         tol_ff       <= tol_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_index_ff <= rsp_index_in;
      rsp_new_ff   <= rsp_new_in;
      rsp_full_ff  <= rsp_full_in;
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_vertex_index = rsp_index_ff;
   assign rsp_is_new       = rsp_new_ff;
   assign rsp_store_full   = rsp_full_ff;

   // ------------------------------------------------------------------
   // Checks
   // ------------------------------------------------------------------
   a_rsp_after_scan: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> $past(state_ff == S_SCAN))
      else $error("result strobe without a finished search");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= DEPTH_CNT)
      else $error("local count beyond store depth");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy)
      else $error("accepted item did not raise busy");

   a_chain_in_range: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && tok_valid[NUM_COMP]) |->
         (CNT_W'(tok_idx[NUM_COMP]) < count_ff))
      else $error("chain returned an entry beyond the local count");

   a_new_not_full_store: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_is_new) |-> $past(store_room))
      else $error("vertex appended to a full store");

endmodule
